// ===== rtl/dfg_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal formatter package
// Shared constants, register indexes and the format configuration type.
// ----------------------------------------------------------------------------
package dfg_pkg;

  localparam int VALUE_W       = 64;
  localparam int BCD_DIGITS    = 20;
  localparam int BCD_W         = 4 * BCD_DIGITS;
  localparam int BITS_PER_STEP = 3;
  localparam int BIN_W         = 66;
  localparam int STEPS         = BIN_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(STEPS);
  localparam int NARROW_DIGITS = 10;
  localparam int CHAR_W        = 8;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2c;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_WIDE_MODE   = 2'd0;
  localparam logic [1:0] REG_GROUP_SEP   = 2'd1;
  localparam logic [1:0] REG_STRIP_LEAD  = 2'd2;

  typedef struct packed {
    logic wide_mode;
    logic group_separators;
    logic strip_leading;
  } fmt_cfg_t;

endpackage

// ===== rtl/dfg_convert.sv =====
// ----------------------------------------------------------------------------
// Decimal formatter front end
// Takes numbers, converts each to twenty BCD digits, three bits per cycle.
// ----------------------------------------------------------------------------
module dfg_convert
  import dfg_pkg::*;
#(
  parameter int DIG_W = 80
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [VALUE_W-1:0] in_tdata,
  output logic               q_valid,
  input  logic               q_ready,
  output logic [DIG_W-1:0]   q_data
);

  logic [VALUE_W-1:0] hold_r;
  logic               hold_v_r;
  logic               busy_r;
  logic               done_r;
  logic [STEP_W-1:0]  cnt_r;
  logic [BIN_W-1:0]   bin_r;
  logic [BCD_W-1:0]   bcd_r;
  logic [BIN_W-1:0]   bin_nxt;
  logic [BCD_W-1:0]   bcd_nxt;
  logic               start;

  assign in_tready = !hold_v_r;
  assign start     = hold_v_r && !busy_r && (!done_r || q_ready);
  assign q_valid   = done_r;
  assign q_data    = bcd_r[DIG_W-1:0];

  always_comb begin
    logic [BCD_W-1:0] b;
    logic [BIN_W-1:0] v;
    b = bcd_r;
    v = bin_r;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (b[4*d +: 4] >= 4'd5) begin
          b[4*d +: 4] = b[4*d +: 4] + 4'd3;
        end
      end
      {b, v} = {b[BCD_W-2:0], v, 1'b0};
    end
    bcd_nxt = b;
    bin_nxt = v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        hold_v_r <= 1'b1;
      end else if (start) begin
        hold_v_r <= 1'b0;
      end
      if (done_r && q_ready) begin
        done_r <= 1'b0;
      end
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hold_r <= in_tdata;
    end
    if (start) begin
      bin_r <= {{(BIN_W - VALUE_W){1'b0}}, hold_r};
      bcd_r <= '0;
    end else if (busy_r) begin
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
    end
  end

  a_busy_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !done_r)
    else $error("converter busy while a result is pending");

endmodule

// ===== rtl/dfg_queue.sv =====
// ----------------------------------------------------------------------------
// Decimal formatter queue
// Two-entry register queue between the converter and the character emitter.
// ----------------------------------------------------------------------------
module dfg_queue
  import dfg_pkg::*;
#(
  parameter int W = 80
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;
  logic         do_push;
  logic         do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/dfg_emit.sv =====
// ----------------------------------------------------------------------------
// Decimal formatter back end
// Walks the digits of one number and emits digits, commas and, unless stripped, blanks.
// ----------------------------------------------------------------------------
module dfg_emit
  import dfg_pkg::*;
#(
  parameter int MAX_DIGITS = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fmt_cfg_t                cfg,
  input  logic                    pop_valid,
  output logic                    pop_ready,
  input  logic [4*MAX_DIGITS-1:0] pop_data,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [CHAR_W-1:0]       out_tdata,
  output logic                    out_tlast
);

  localparam int DIG_W = 4 * MAX_DIGITS;
  localparam int RW    = $clog2(MAX_DIGITS);
  localparam logic [1:0] TOP_M3    = 2'((MAX_DIGITS - 1) % 3);
  localparam logic [1:0] NARROW_M3 = 2'((NARROW_DIGITS - 1) % 3);
  localparam int NARROW_SH = 4 * (MAX_DIGITS - NARROW_DIGITS);

  logic              busy_r;
  logic              in_comma_r;
  logic              seen_r;
  logic [RW-1:0]     r_r;
  logic [1:0]        m3_r;
  logic [DIG_W-1:0]  sh_r;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;

  logic [3:0]        digit;
  logic              seen_post;
  logic              blank;
  logic              emit;
  logic              has_comma;
  logic              is_last;
  logic              step;
  logic              load;
  logic [CHAR_W-1:0] ch;

  assign digit      = sh_r[DIG_W-1 -: 4];
  assign seen_post  = seen_r || (digit != 4'd0) || (r_r == '0);
  assign blank      = in_comma_r ? !seen_r : !seen_post;
  assign ch         = blank ? CH_SPACE : (in_comma_r ? CH_COMMA : (CH_ZERO + {4'd0, digit}));
  assign emit       = !(cfg.strip_leading && blank);
  assign has_comma  = cfg.group_separators && (r_r != '0) && (m3_r == 2'd0);
  assign is_last    = !in_comma_r && (r_r == '0);
  assign step       = busy_r && (!out_valid_r || out_tready);
  assign pop_ready  = !busy_r || (step && is_last);
  assign load       = pop_valid && pop_ready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      in_comma_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (step && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        busy_r     <= 1'b1;
        in_comma_r <= 1'b0;
      end else if (step) begin
        if (is_last) begin
          busy_r <= 1'b0;
        end
        in_comma_r <= !in_comma_r && has_comma;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_char_r <= ch;
      out_last_r <= is_last;
    end
    if (load) begin
      seen_r <= 1'b0;
      if (cfg.wide_mode) begin
        r_r  <= RW'(MAX_DIGITS - 1);
        m3_r <= TOP_M3;
        sh_r <= pop_data;
      end else begin
        r_r  <= RW'(NARROW_DIGITS - 1);
        m3_r <= NARROW_M3;
        sh_r <= pop_data << NARROW_SH;
      end
    end else if (step) begin
      if (!in_comma_r) begin
        seen_r <= seen_post;
      end
      if (in_comma_r || !has_comma) begin
        r_r  <= r_r - 1'b1;
        m3_r <= (m3_r == 2'd0) ? 2'd2 : m3_r - 2'd1;
        sh_r <= sh_r << 4;
      end
    end
  end

  a_load_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (load && busy_r) |-> (r_r == '0 && !in_comma_r))
    else $error("new number loaded before the previous one finished");

  a_comma_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_comma_r |-> busy_r)
    else $error("comma slot outside a number");

  a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata != CH_SPACE && out_tdata != CH_COMMA))
    else $error("final character is not a digit");

endmodule

// ===== rtl/decimal_formatter_with_grouping.sv =====
// ----------------------------------------------------------------------------
// Decimal formatter with grouping
// Converts 64-bit unsigned numbers to ASCII decimal text with optional commas.
// ----------------------------------------------------------------------------
// Numbers overlap: the converter can accept a new number while it is still
// converting the previous one, and the emitter takes another number from the
// queue as it steps through the last character of the current one. The emitter
// steps through each digit and comma position (up to 26), including blanks
// skipped in strip mode.
// Reset: registers go to wide_mode 1, group_separators 1, strip_leading 0,
// and the converter, queue and emitter are emptied.
module decimal_formatter_with_grouping
  import dfg_pkg::*;
#(
  parameter int MAX_DIGITS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [VALUE_W-1:0]    in_tdata,    // value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [CHAR_W-1:0]     out_tdata,   // character
  output logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int DIG_W = 4 * MAX_DIGITS;

  fmt_cfg_t          cfg_r;
  logic              cfg_wr;
  logic [1:0]        reg_idx;
  logic              q_in_valid;
  logic              q_in_ready;
  logic [DIG_W-1:0]  q_in_data;
  logic              q_out_valid;
  logic              q_out_ready;
  logic [DIG_W-1:0]  q_out_data;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wide_mode        <= 1'b1;
      cfg_r.group_separators <= 1'b1;
      cfg_r.strip_leading    <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WIDE_MODE:  cfg_r.wide_mode        <= cfg_pwdata[0];
        REG_GROUP_SEP:  cfg_r.group_separators <= cfg_pwdata[0];
        REG_STRIP_LEAD: cfg_r.strip_leading    <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDE_MODE:  cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_r.wide_mode};
      REG_GROUP_SEP:  cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_r.group_separators};
      REG_STRIP_LEAD: cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_r.strip_leading};
      default:        cfg_prdata = '0;
    endcase
  end

  dfg_convert #(
    .DIG_W (DIG_W)
  ) u_convert (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_in_valid),
    .q_ready   (q_in_ready),
    .q_data    (q_in_data)
  );

  dfg_queue #(
    .W (DIG_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_data  (q_in_data),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_data   (q_out_data)
  );

  dfg_emit #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_data   (q_out_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Decimal formatter with grouping testbench
// Sends 64-bit numbers through the stream input and checks every character on
// the stream output against a predicted text row, under every combination of
// digit count, comma grouping and blank stripping. Both stream sides idle at
// random, and the receiver once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module testbench;
  import dfg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TB_MAX_DIGITS = 20;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int LONG_HOLD     = 500;
  localparam int ROW_MAX       = 27;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_beat_t;

  class text_scoreboard;
    bit           wide_mode;
    bit           group_separators;
    bit           strip_leading;
    char_beat_t   pending_chars[$];
    int           fail_count;
    int           char_index;

    function new();
      wide_mode        = 1'b1;
      group_separators = 1'b1;
      strip_leading    = 1'b0;
      fail_count       = 0;
      char_index       = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WIDE_MODE:  wide_mode = data[0];
        REG_GROUP_SEP:  group_separators = data[0];
        REG_STRIP_LEAD: strip_leading = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction

    function void predict_text(logic [VALUE_W-1:0] value);
      logic [CHAR_W-1:0]  row [0:ROW_MAX-1];
      logic [3:0]         digs [0:BCD_DIGITS-1];
      logic [VALUE_W-1:0] rest;
      int                 nd;
      int                 len;
      int                 i;
      int                 first;
      char_beat_t         beat;
      nd = wide_mode ? TB_MAX_DIGITS : NARROW_DIGITS;
      if (nd > BCD_DIGITS) nd = BCD_DIGITS;
      if (nd < 1) nd = 1;
      rest = value;
      for (i = nd - 1; i >= 0; i--) begin
        digs[i] = 4'(rest % 64'd10);
        rest = rest / 64'd10;
      end
      len = 0;
      for (i = 0; i < nd; i++) begin
        row[len] = CH_ZERO + CHAR_W'(digs[i]);
        len++;
        if (group_separators && (nd - 1 - i) > 0 && ((nd - 1 - i) % 3) == 0) begin
          row[len] = CH_COMMA;
          len++;
        end
      end
      i = 0;
      while (i < len && (row[i] == CH_ZERO || row[i] == CH_COMMA)) begin
        row[i] = CH_SPACE;
        i++;
      end
      if (row[len-1] == CH_SPACE) row[len-1] = CH_ZERO;
      first = 0;
      if (strip_leading) begin
        while (first < len - 1 && row[first] == CH_SPACE) first++;
      end
      for (i = first; i < len; i++) begin
        beat.ch   = row[i];
        beat.last = (i == len - 1);
        pending_chars.push_back(beat);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] ch, logic last);
      char_beat_t want;
      char_index++;
      if (pending_chars.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("character %0d: unexpected transfer, got char %h last %b",
                   char_index, ch, last);
        return;
      end
      want = pending_chars.pop_front();
      if (want.ch !== ch || want.last !== last) begin
        fail_count++;
        if (fail_count <= 10)
          $display("character %0d: expected char %h last %b, got char %h last %b",
                   char_index, want.ch, want.last, ch, last);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [VALUE_W-1:0]    in_tdata;    // value
  logic                  out_tvalid;
  logic                  out_tready;
  logic [CHAR_W-1:0]     out_tdata;   // character
  logic                  out_tlast;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  text_scoreboard sb = new();
  int             cycle_count = 0;
  int             rx_mode = 0;
  bit             long_hold_req = 1'b0;
  logic [VALUE_W-1:0] pow10 [0:19];

  decimal_formatter_with_grouping #(
    .MAX_DIGITS(TB_MAX_DIGITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_char(out_tdata, out_tlast);
  end

  initial begin : receiver
    int hold_left;
    int tick;
    hold_left = 0;
    tick = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ((tick % 11) < 7);
          default: out_tready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  task automatic send_value(logic [VALUE_W-1:0] value);
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    sb.predict_text(value);
  endtask

  task automatic hold_input(int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, bit val);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom();
    data[0] = val;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, data);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0: random_value = v;
      1: random_value = VALUE_W'($urandom_range(0, 999));
      2: random_value = v >> $urandom_range(0, 63);
      3: random_value = pow10[$urandom_range(0, 19)] + VALUE_W'($urandom_range(0, 2)) - 1;
      4: random_value = pow10[$urandom_range(1, 19)] - 1;
      default: random_value = v % pow10[$urandom_range(0, 19)];
    endcase
  endfunction

  initial begin : stimulus
    logic [VALUE_W-1:0] directed_a [0:16];
    logic [VALUE_W-1:0] directed_b [0:5];
    int phase;
    int left;
    int burst;
    int k;
    directed_a = '{
      64'd0, 64'd1, 64'd9, 64'd10, 64'd999, 64'd1000, 64'd1234567,
      64'd9999999999, 64'd10000000000, 64'd12345678901,
      64'd999999999999999999, 64'd9999999999999999999,
      64'd10000000000000000000, 64'h8000_0000_0000_0000,
      64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
      64'hFFFF_FFFF_FFFF_FFFF
    };
    directed_b = '{
      64'd0, 64'd7, 64'd10000000000, 64'd9999999999, 64'hFFFF_FFFF_FFFF_FFFF,
      64'd1000000
    };
    pow10[0] = 64'd1;
    for (k = 1; k < 20; k++) pow10[k] = pow10[k-1] * 64'd10;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_a[i]) begin
      send_value(directed_a[i]);
      hold_input($urandom_range(0, 3));
    end
    wait_idle();
    cfg_write(REG_WIDE_MODE, 1'b0);
    cfg_write(REG_STRIP_LEAD, 1'b1);
    cfg_write(REG_UNUSED, 1'b0);
    foreach (directed_b[i]) send_value(directed_b[i]);

    for (phase = 0; phase < 8; phase++) begin
      wait_idle();
      cfg_write(REG_WIDE_MODE, phase[0]);
      cfg_write(REG_GROUP_SEP, phase[1]);
      cfg_write(REG_STRIP_LEAD, phase[2]);
      rx_mode = phase % 4;
      if (phase == 5) begin
        long_hold_req = 1'b1;
        for (k = 0; k < 14; k++) send_value(random_value());
      end else begin
        left = 14;
        while (left > 0) begin
          burst = $urandom_range(1, 8);
          while (burst > 0 && left > 0) begin
            send_value(random_value());
            burst--;
            left--;
            if (phase == 3 && left == 8) wait_idle();
          end
          if (phase != 6) hold_input($urandom_range(0, 12));
        end
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
